// File: rtl/bfw_pkg.sv
// shared types and constants of the bmp to framebuffer writer
// no dependencies; imported by every module of the block
package bfw_pkg;

  localparam int DimW        = 13;
  localparam int AddrW       = 26;
  localparam int MaxDim      = 4096;
  localparam int HeaderBytes = 54;
  localparam int QueueDepth  = 4;
  localparam int QPtrW       = $clog2(QueueDepth);

  localparam logic [15:0] BmpType = 16'h4D42;
  localparam logic [15:0] BmpBpp  = 16'd24;

  localparam logic [DimW-1:0] FrameWidthReset  = 13'd1280;
  localparam logic [DimW-1:0] FrameHeightReset = 13'd720;

  // parser phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_IDLE   = 2'd3;

  // status codes
  localparam logic [2:0] ST_NONE       = 3'd0;
  localparam logic [2:0] ST_HEADER_OK  = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd2;
  localparam logic [2:0] ST_NOT_BMP    = 3'd3;
  localparam logic [2:0] ST_NOT_24BIT  = 3'd4;
  localparam logic [2:0] ST_COMPRESSED = 3'd5;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd6;
  localparam logic [2:0] ST_DONE       = 3'd7;

  // configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // one classified word from the parser to the address stage
  typedef struct packed {
    logic            wr;
    logic [DimW-1:0] row;
    logic [DimW-1:0] col;
    logic [1:0]      chan;
    logic [7:0]      data;
    logic [2:0]      status;
  } bfw_entry_t;

endpackage

// File: rtl/bfw_front.sv
// parser front end: header decode, skip to data, pixel position tracking
// depends on bfw_pkg
module bfw_front import bfw_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            start_of_file,
  input  logic            last_byte,
  input  logic [DimW-1:0] frame_width,
  input  logic [DimW-1:0] frame_height,
  output bfw_entry_t      ent
);

  logic [1:0]      phase, c_phase, phase_next;
  logic [31:0]     byte_count, c_bc, bc_next;
  logic [15:0]     hdr_type, c_type, type_next;
  logic [15:0]     hdr_bpp, c_bpp, bpp_next;
  logic            comp_nz, c_comp, comp_next;
  logic [31:0]     data_offset, c_doff, doff_next;
  logic [DimW-1:0] img_w, c_w, w_next;
  logic            w_big, c_wbig, wbig_next;
  logic [DimW-1:0] img_h, c_h, h_next;
  logic            h_big, c_hbig, hbig_next;
  logic [DimW-1:0] column, c_col, col_next;
  logic [DimW-1:0] row, c_row, row_next;
  logic [1:0]      channel, c_chan, chan_next;
  logic [1:0]      pad_count, c_pad, pad_next;

  logic [31:0]     pos;
  logic [DimW-1:0] col_inc;
  logic            in_data;
  logic            w_bad, h_bad;

  // start of file restarts parsing with this word as header byte zero
  always_comb begin
    if (start_of_file) begin
      c_phase = PH_HEADER; c_bc = '0; c_type = '0; c_bpp = '0; c_comp = 1'b0;
      c_doff = '0; c_w = '0; c_wbig = 1'b0; c_h = '0; c_hbig = 1'b0;
      c_col = '0; c_row = '0; c_chan = 2'd2; c_pad = '0;
    end else begin
      c_phase = phase; c_bc = byte_count; c_type = hdr_type; c_bpp = hdr_bpp;
      c_comp = comp_nz; c_doff = data_offset; c_w = img_w; c_wbig = w_big;
      c_h = img_h; c_hbig = h_big; c_col = column; c_row = row;
      c_chan = channel; c_pad = pad_count;
    end
  end

  assign pos     = c_bc;
  assign col_inc = c_col + 13'd1;
  assign in_data = (c_phase == PH_DATA) || ((c_phase == PH_SKIP) && (pos >= c_doff));
  assign w_bad   = c_wbig || (c_w == '0) || (c_w > DimW'(MaxDim));
  assign h_bad   = c_hbig || (c_h == '0) || (c_h > DimW'(MaxDim));

  always_comb begin
    phase_next = c_phase; type_next = c_type; bpp_next = c_bpp; comp_next = c_comp;
    doff_next = c_doff; w_next = c_w; wbig_next = c_wbig; h_next = c_h;
    hbig_next = c_hbig; col_next = c_col; row_next = c_row; chan_next = c_chan;
    pad_next = c_pad;
    bc_next = (c_bc == 32'hFFFF_FFFF) ? c_bc : c_bc + 32'd1;
    ent = '0;

    case (c_phase)
      PH_HEADER: begin
        case (pos)
          32'd0:  type_next[7:0]   = data_byte;
          32'd1:  type_next[15:8]  = data_byte;
          32'd10: doff_next[7:0]   = data_byte;
          32'd11: doff_next[15:8]  = data_byte;
          32'd12: doff_next[23:16] = data_byte;
          32'd13: doff_next[31:24] = data_byte;
          32'd18: w_next[7:0]      = data_byte;
          32'd19: begin
            w_next[12:8] = data_byte[4:0];
            wbig_next    = c_wbig | (|data_byte[7:5]);
          end
          32'd20, 32'd21: wbig_next = c_wbig | (|data_byte);
          32'd22: h_next[7:0]      = data_byte;
          32'd23: begin
            h_next[12:8] = data_byte[4:0];
            hbig_next    = c_hbig | (|data_byte[7:5]);
          end
          32'd24, 32'd25: hbig_next = c_hbig | (|data_byte);
          32'd28: bpp_next[7:0]    = data_byte;
          32'd29: bpp_next[15:8]   = data_byte;
          32'd30, 32'd31, 32'd32, 32'd33: comp_next = c_comp | (|data_byte);
          default: ;
        endcase

        // header complete: checks in priority order
        if (pos == 32'(HeaderBytes - 1)) begin
          phase_next = PH_IDLE;
          if (c_type != BmpType) begin
            ent.status = ST_NOT_BMP;
          end else if (c_bpp != BmpBpp) begin
            ent.status = ST_NOT_24BIT;
          end else if (c_comp) begin
            ent.status = ST_COMPRESSED;
          end else if (w_bad || h_bad) begin
            ent.status = ST_BAD_SIZE;
          end else begin
            ent.status = ST_HEADER_OK;
            phase_next = PH_SKIP;
            col_next   = '0;
            row_next   = c_h - 13'd1;
            chan_next  = 2'd2;
            pad_next   = '0;
          end
        end
        if (last_byte && (pos < 32'(HeaderBytes - 1))) begin
          ent.status = ST_TOO_SHORT;
        end
      end
      PH_SKIP, PH_DATA: begin
        if (in_data) begin
          phase_next = PH_DATA;
          if (c_pad != '0) begin
            pad_next = c_pad - 2'd1;
          end else begin
            ent.wr   = (c_col < frame_width) && (c_row < frame_height);
            ent.row  = c_row;
            ent.col  = c_col;
            ent.chan = c_chan;
            ent.data = ent.wr ? data_byte : 8'd0;
            if (c_chan != 2'd0) begin
              chan_next = c_chan - 2'd1;
            end else begin
              chan_next = 2'd2;
              if (col_inc >= c_w) begin
                col_next = '0;
                if (c_row == '0) begin
                  ent.status = ST_DONE;
                  phase_next = PH_IDLE;
                end else begin
                  row_next = c_row - 13'd1;
                  pad_next = c_w[1:0];
                end
              end else begin
                col_next = col_inc;
              end
            end
          end
        end
      end
      default: ;
    endcase

    // end of stream: next word starts a new file
    if (last_byte) begin
      phase_next = PH_HEADER; bc_next = '0; type_next = '0; bpp_next = '0;
      comp_next = 1'b0; doff_next = '0; w_next = '0; wbig_next = 1'b0;
      h_next = '0; hbig_next = 1'b0; col_next = '0; row_next = '0;
      chan_next = 2'd2; pad_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER; byte_count <= '0; hdr_type <= '0; hdr_bpp <= '0;
      comp_nz <= 1'b0; data_offset <= '0; img_w <= '0; w_big <= 1'b0;
      img_h <= '0; h_big <= 1'b0; column <= '0; row <= '0;
      channel <= 2'd2; pad_count <= '0;
    end else if (accept) begin
      phase <= phase_next; byte_count <= bc_next; hdr_type <= type_next;
      hdr_bpp <= bpp_next; comp_nz <= comp_next; data_offset <= doff_next;
      img_w <= w_next; w_big <= wbig_next; img_h <= h_next; h_big <= hbig_next;
      column <= col_next; row <= row_next; channel <= chan_next;
      pad_count <= pad_next;
    end
  end

endmodule

// File: rtl/bfw_queue.sv
// short register queue between the parser and the address stage
// depends on bfw_pkg
module bfw_queue import bfw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  bfw_entry_t din,
  input  logic       pop,
  output bfw_entry_t dout,
  output logic       full,
  output logic       empty
);

  bfw_entry_t       mem [QueueDepth];
  logic [QPtrW-1:0] wptr, rptr;
  logic [QPtrW:0]   count;

  assign full  = (count == (QPtrW+1)'(QueueDepth));
  assign empty = (count == '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/bfw_back.sv
// back end: row stride multiply, address add and output register
// depends on bfw_pkg
module bfw_back import bfw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  bfw_entry_t       q_dout,
  output logic             q_pop,
  input  logic [DimW-1:0]  frame_width,
  input  logic             pop,
  output logic             empty,
  output logic             write_valid,
  output logic [AddrW-1:0] write_address,
  output logic [7:0]       write_data,
  output logic [2:0]       status
);

  logic             s1_v;
  logic [AddrW-1:0] s1_prod;
  bfw_entry_t       s1_ent;
  logic             o_v;
  logic             o_ready, s1_ready;
  logic [AddrW-1:0] q_prod, addr_sum;

  assign o_ready  = !o_v || pop;
  assign s1_ready = !s1_v || o_ready;
  assign q_pop    = !q_empty && s1_ready;

  assign q_prod   = AddrW'(q_dout.row) * AddrW'(frame_width);
  // (row*stride + col)*4 + chan, wrapping to the address width
  assign addr_sum = {s1_prod[AddrW-3:0], 2'b00}
                  + {{(AddrW-DimW-2){1'b0}}, s1_ent.col, 2'b00}
                  + {{(AddrW-2){1'b0}}, s1_ent.chan};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      o_v  <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v <= !q_empty;
      end
      if (o_ready) begin
        o_v <= s1_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_prod <= q_prod;
      s1_ent  <= q_dout;
    end
    if (s1_v && o_ready) begin
      write_valid   <= s1_ent.wr;
      write_address <= s1_ent.wr ? addr_sum : '0;
      write_data    <= s1_ent.data;
      status        <= s1_ent.status;
    end
  end

  assign empty = !o_v;

endmodule

// File: rtl/bmp_to_framebuffer_writer.sv
// bmp to framebuffer writer top level: config registers, parser, queue, back end
// depends on bfw_pkg, bfw_front, bfw_queue, bfw_back
// a taken word passes through the queue, the stride multiply register and the output register
// throughput: one word per cycle while the queue has room, set by the parser's state update
// every accepted word gives exactly one result word
// reset (rst, synchronous): clears parser state, queue and output stage;
// frame_width returns to 1280 and frame_height to 720
module bmp_to_framebuffer_writer import bfw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // input side, queue style
  input  logic             push,
  output logic             full,
  input  logic [7:0]       data_byte,
  input  logic             start_of_file,
  input  logic             last_byte,
  // result side, queue style
  output logic             empty,
  input  logic             pop,
  output logic             write_valid,
  output logic [AddrW-1:0] write_address,
  output logic [7:0]       write_data,
  output logic [2:0]       status,
  // configuration write port
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [DimW-1:0]  cfg_data
);

  logic [DimW-1:0] frame_width;
  logic [DimW-1:0] frame_height;
  logic            accept;
  bfw_entry_t      front_ent;
  bfw_entry_t      q_dout;
  logic            q_empty;
  logic            q_pop;

  // configuration registers; the user must write them only while no word is in flight, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FrameWidthReset;
      frame_height <= FrameHeightReset;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // a word is taken whenever the queue has room, even if a result waits
  assign accept = push && !full;

  // front: header parse and pixel position, one word per cycle while the queue has room
  bfw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .start_of_file(start_of_file),
    .last_byte    (last_byte),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .ent          (front_ent)
  );

  // decoupling queue: lets the parser run while the output is stalled
  bfw_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (accept),
    .din  (front_ent),
    .pop  (q_pop),
    .dout (q_dout),
    .full (full),
    .empty(q_empty)
  );

  // back: stride multiply, then address add into the output register
  bfw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_dout       (q_dout),
    .q_pop        (q_pop),
    .frame_width  (frame_width),
    .pop          (pop),
    .empty        (empty),
    .write_valid  (write_valid),
    .write_address(write_address),
    .write_data   (write_data),
    .status       (status)
  );

endmodule

// File: rtl/bfw_checker.sv
// port-level checks for the bmp to framebuffer writer, bound to the top level
// depends on bfw_pkg and bmp_to_framebuffer_writer
module bfw_checker import bfw_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic             write_valid,
  input logic [AddrW-1:0] write_address,
  input logic [7:0]       write_data,
  input logic [2:0]       status
);

  // reset leaves no result waiting and room for input
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("result or full flag present after reset");

  // a waiting result that is not taken stays as it is
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(write_address) && $stable(write_data)
                          && $stable(write_valid) && $stable(status)))
    else $error("waiting result changed before it was taken");

  // a word without a write carries zero address and data
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !write_valid) |-> (write_address == '0 && write_data == '0))
    else $error("address or data set on a word without a write");

  // header and error reports never come with a pixel write
  a_status_nowrite: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status == ST_HEADER_OK || status == ST_TOO_SHORT ||
                status == ST_NOT_BMP || status == ST_NOT_24BIT ||
                status == ST_COMPRESSED || status == ST_BAD_SIZE)) |-> !write_valid)
    else $error("header status reported together with a write");

endmodule

bind bmp_to_framebuffer_writer bfw_checker u_bfw_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .write_valid  (write_valid),
  .write_address(write_address),
  .write_data   (write_data),
  .status       (status)
);
